@@ src/gbi_pkg.sv @@
// Shared constants and types for the bilinear grid interpolator.
package gbi_pkg;

  localparam int MAX_POINTS_R = 64;
  localparam int MAX_POINTS_Z = 64;
  localparam int TABLE_DEPTH  = MAX_POINTS_R * MAX_POINTS_Z;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int CELL_R_W     = $clog2(MAX_POINTS_R);
  localparam int CELL_Z_W     = $clog2(MAX_POINTS_Z);
  localparam int PTS_W        = 7;
  localparam int FRAC_W       = 17;
  localparam int PIPE_LATENCY = 10;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_R_LOWER    = 3'd0,
    REG_R_UPPER    = 3'd1,
    REG_Z_LOWER    = 3'd2,
    REG_Z_UPPER    = 3'd3,
    REG_R_STEP_INV = 3'd4,
    REG_Z_STEP_INV = 3'd5,
    REG_POINTS_R   = 3'd6,
    REG_POINTS_Z   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic eval;
    logic oob;
  } item_ctl_t;

  typedef struct packed {
    logic signed [31:0] r_lower;
    logic signed [31:0] r_upper;
    logic signed [31:0] z_lower;
    logic signed [31:0] z_upper;
    logic [31:0]        r_step_inv;
    logic [31:0]        z_step_inv;
    logic [PTS_W-1:0]   points_r;
    logic [PTS_W-1:0]   points_z;
  } grid_cfg_t;

endpackage

@@ src/gbi_locate.sv @@
// Bounds check, offset scaling and cell/fraction split for both axes (three stages).
module gbi_locate import gbi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                acc,
  input  logic                eval,
  input  logic signed [31:0]  coord_r,
  input  logic signed [31:0]  coord_z,
  input  grid_cfg_t           cfg,
  output item_ctl_t           ctl,
  output logic [CELL_R_W-1:0] cell_r,
  output logic [CELL_Z_W-1:0] cell_z,
  output logic [FRAC_W-1:0]   frac_r,
  output logic [FRAC_W-1:0]   frac_z
);

  item_ctl_t   ctl1;
  item_ctl_t   ctl2;
  logic        oob_in;
  logic [31:0] off_r;
  logic [31:0] off_z;
  logic [63:0] prod_r;
  logic [63:0] prod_z;

  logic             clamp_r;
  logic             clamp_z;
  logic [PTS_W-1:0] last_r;
  logic [PTS_W-1:0] last_z;

  assign oob_in = (coord_r < cfg.r_lower) || (coord_r > cfg.r_upper) ||
                  (coord_z < cfg.z_lower) || (coord_z > cfg.z_upper);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl  <= '0;
    end else begin
      ctl1 <= '{valid: acc, eval: eval, oob: oob_in};
      ctl2 <= ctl1;
      ctl  <= ctl2;
    end
  end

  // offsets are nonnegative whenever the point is in bounds
  always_ff @(posedge clk) begin
    off_r  <= 32'(coord_r - cfg.r_lower);
    off_z  <= 32'(coord_z - cfg.z_lower);
    prod_r <= 64'(off_r) * 64'(cfg.r_step_inv);
    prod_z <= 64'(off_z) * 64'(cfg.z_step_inv);
  end

  // past the last cell: use the last cell with fraction 1.0
  always_comb begin
    clamp_r = prod_r[63:32] >= 32'(cfg.points_r - PTS_W'(1));
    clamp_z = prod_z[63:32] >= 32'(cfg.points_z - PTS_W'(1));
    last_r  = cfg.points_r - PTS_W'(2);
    last_z  = cfg.points_z - PTS_W'(2);
  end

  always_ff @(posedge clk) begin
    if (clamp_r) begin
      cell_r <= last_r[CELL_R_W-1:0];
      frac_r <= FRAC_ONE;
    end else begin
      cell_r <= prod_r[32 +: CELL_R_W];
      frac_r <= {1'b0, prod_r[31:16]};
    end
    if (clamp_z) begin
      cell_z <= last_z[CELL_Z_W-1:0];
      frac_z <= FRAC_ONE;
    end else begin
      cell_z <= prod_z[32 +: CELL_Z_W];
      frac_z <= {1'b0, prod_z[31:16]};
    end
  end

endmodule

@@ src/gbi_mem.sv @@
// Sample table: two copies, one per grid row of the cell, two read ports each.
module gbi_mem import gbi_pkg::*; (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic signed [31:0] wr_data,
  input  logic [ADDR_W-1:0]  base,
  input  logic [PTS_W-1:0]   points_r,
  output logic signed [31:0] c00,
  output logic signed [31:0] c10,
  output logic signed [31:0] c01,
  output logic signed [31:0] c11
);

  logic [31:0] row_lo [TABLE_DEPTH];
  logic [31:0] row_hi [TABLE_DEPTH];

  logic [ADDR_W-1:0] addr_10;
  logic [ADDR_W-1:0] addr_01;
  logic [ADDR_W-1:0] addr_11;

  assign addr_10 = base + ADDR_W'(1);
  assign addr_01 = base + ADDR_W'(points_r);
  assign addr_11 = addr_01 + ADDR_W'(1);

  // both copies take every load, so each stays a full image of the table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_lo[wr_addr] <= wr_data;
    end
    c00 <= $signed(row_lo[base]);
    c10 <= $signed(row_lo[addr_10]);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_hi[wr_addr] <= wr_data;
    end
    c01 <= $signed(row_hi[addr_01]);
    c11 <= $signed(row_hi[addr_11]);
  end

endmodule

@@ src/gbi_blend.sv @@
// Two-stage linear blend a + (b - a) * f, rounded half up, f in Q1.16 up to 1.0.
module gbi_blend import gbi_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic [FRAC_W-1:0]  f,
  output logic signed [31:0] y
);

  logic signed [31:0] a_q;
  logic signed [32:0] d_q;
  logic [FRAC_W-1:0]  f_q;
  logic signed [50:0] prod;
  logic signed [51:0] sum;

  always_ff @(posedge clk) begin
    a_q <= a;
    d_q <= 33'(b) - 33'(a);
    f_q <= f;
  end

  assign prod = 51'(d_q) * 51'($signed({1'b0, f_q}));
  assign sum  = (52'(a_q) <<< 16) + 52'(prod) + 52'sd32768;

  // result lies between a and b, so the floor shift fits in 32 bits
  always_ff @(posedge clk) begin
    y <= $signed(sum[47:16]);
  end

endmodule

@@ src/bilinear_grid_interpolator.sv @@
// Bilinear interpolator on a regular 2D grid: config registers, pipeline control and datapath.
// An evaluate word passes the locate stages and ctl4 to ctl9, then sets the strobe register.
// Throughput: one word per cycle, loads and evaluates mixed freely; busy is low outside reset.
// Loads write the table from the ctl4 stage, in order with the reads of evaluates.
// Reset clears config registers to defaults and empties the pipeline; table contents persist.
// Output has no backpressure: strobe, value and status hold for one cycle only.
module bilinear_grid_interpolator import gbi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                cmd,
  input  logic [ADDR_W-1:0]   load_index,
  input  logic signed [31:0]  load_value,
  input  logic signed [31:0]  coord_r,
  input  logic signed [31:0]  coord_z,
  output logic                strobe,
  output logic signed [31:0]  value,
  output logic                status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam logic [PTS_W-1:0] PTS_MIN   = PTS_W'(2);
  localparam logic [PTS_W-1:0] PTS_MAX_R = PTS_W'(MAX_POINTS_R);
  localparam logic [PTS_W-1:0] PTS_MAX_Z = PTS_W'(MAX_POINTS_Z);

  grid_cfg_t cfg;
  logic      acc;
  logic      eval_in;

  item_ctl_t           ctl3;
  logic [CELL_R_W-1:0] cell_r;
  logic [CELL_Z_W-1:0] cell_z;
  logic [FRAC_W-1:0]   frac_r;
  logic [FRAC_W-1:0]   frac_z;

  logic [ADDR_W-1:0]  ld_idx1, ld_idx2, ld_idx3;
  logic signed [31:0] ld_val1, ld_val2, ld_val3;

  item_ctl_t ctl4, ctl5, ctl6, ctl7, ctl8, ctl9;
  logic [ADDR_W-1:0]  base4;
  logic [ADDR_W-1:0]  base_calc;
  logic signed [31:0] wr_data4;
  logic [FRAC_W-1:0]  fr4, fr5;
  logic [FRAC_W-1:0]  fz4, fz5, fz6, fz7;
  logic               wr_en;

  logic signed [31:0] c00, c10, c01, c11;
  logic signed [31:0] c0, c1, v;

  function automatic logic [PTS_W-1:0] sat_pts(input logic [PTS_W-1:0] p,
                                               input logic [PTS_W-1:0] pmax);
    logic [PTS_W-1:0] res;
    if (p < PTS_MIN) begin
      res = PTS_MIN;
    end else if (p > pmax) begin
      res = pmax;
    end else begin
      res = p;
    end
    return res;
  endfunction

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign acc       = start && !busy;
  assign eval_in   = cmd_t'(cmd) == CMD_EVAL;

  // point counts are stored already saturated to the supported range
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.r_lower    <= '0;
      cfg.r_upper    <= '0;
      cfg.z_lower    <= '0;
      cfg.z_upper    <= '0;
      cfg.r_step_inv <= 32'd65536;
      cfg.z_step_inv <= 32'd65536;
      cfg.points_r   <= PTS_MIN;
      cfg.points_z   <= PTS_MIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_R_LOWER:    cfg.r_lower    <= $signed(cfg_data);
        REG_R_UPPER:    cfg.r_upper    <= $signed(cfg_data);
        REG_Z_LOWER:    cfg.z_lower    <= $signed(cfg_data);
        REG_Z_UPPER:    cfg.z_upper    <= $signed(cfg_data);
        REG_R_STEP_INV: cfg.r_step_inv <= cfg_data;
        REG_Z_STEP_INV: cfg.z_step_inv <= cfg_data;
        REG_POINTS_R:   cfg.points_r   <= sat_pts(cfg_data[PTS_W-1:0], PTS_MAX_R);
        REG_POINTS_Z:   cfg.points_z   <= sat_pts(cfg_data[PTS_W-1:0], PTS_MAX_Z);
        default:        ;
      endcase
    end
  end

  gbi_locate u_locate (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .eval    (eval_in),
    .coord_r (coord_r),
    .coord_z (coord_z),
    .cfg     (cfg),
    .ctl     (ctl3),
    .cell_r  (cell_r),
    .cell_z  (cell_z),
    .frac_r  (frac_r),
    .frac_z  (frac_z)
  );

  // load words ride alongside the locate stages so table writes stay in order
  always_ff @(posedge clk) begin
    ld_idx1 <= load_index;
    ld_val1 <= load_value;
    ld_idx2 <= ld_idx1;
    ld_val2 <= ld_val1;
    ld_idx3 <= ld_idx2;
    ld_val3 <= ld_val2;
  end

  assign base_calc = ADDR_W'(cell_z) * ADDR_W'(cfg.points_r) + ADDR_W'(cell_r);

  always_ff @(posedge clk) begin
    base4    <= ctl3.eval ? base_calc : ld_idx3;
    wr_data4 <= ld_val3;
    fr4      <= frac_r;
    fz4      <= frac_z;
    fr5      <= fr4;
    fz5      <= fz4;
    fz6      <= fz5;
    fz7      <= fz6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4   <= '0;
      ctl5   <= '0;
      ctl6   <= '0;
      ctl7   <= '0;
      ctl8   <= '0;
      ctl9   <= '0;
      strobe <= 1'b0;
    end else begin
      ctl4   <= ctl3;
      ctl5   <= ctl4;
      ctl6   <= ctl5;
      ctl7   <= ctl6;
      ctl8   <= ctl7;
      ctl9   <= ctl8;
      strobe <= ctl9.valid && ctl9.eval;
    end
  end

  assign wr_en = ctl4.valid && !ctl4.eval;

  gbi_mem u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (base4),
    .wr_data  (wr_data4),
    .base     (base4),
    .points_r (cfg.points_r),
    .c00      (c00),
    .c10      (c10),
    .c01      (c01),
    .c11      (c11)
  );

  gbi_blend u_blend_lo (
    .clk (clk),
    .a   (c00),
    .b   (c10),
    .f   (fr5),
    .y   (c0)
  );

  gbi_blend u_blend_hi (
    .clk (clk),
    .a   (c01),
    .b   (c11),
    .f   (fr5),
    .y   (c1)
  );

  gbi_blend u_blend_z (
    .clk (clk),
    .a   (c0),
    .b   (c1),
    .f   (fz7),
    .y   (v)
  );

  always_ff @(posedge clk) begin
    status <= ctl9.oob;
    value  <= ctl9.oob ? '0 : v;
  end

endmodule

@@ src/gbi_checker.sv @@
// Port-level checks for the bilinear grid interpolator, bound to the top level.
module gbi_checker import gbi_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               cmd,
  input logic               strobe,
  input logic signed [31:0] value,
  input logic               status
);

  logic eval_acc;

  assign eval_acc = start && !busy && (cmd_t'(cmd) == CMD_EVAL);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe after reset");

  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && status |-> value == '0)
    else $error("out-of-range word with nonzero value");

  a_eval_result: assert property (@(posedge clk) disable iff (rst)
    eval_acc |-> ##PIPE_LATENCY strobe)
    else $error("evaluate word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !eval_acc |-> ##PIPE_LATENCY !strobe)
    else $error("result without a matching evaluate word");

endmodule

bind bilinear_grid_interpolator gbi_checker u_gbi_checker (.*);

@@ verif/bilinear_grid_checker.sv @@
// Checker for the bilinear grid interpolator: predicts each evaluate word and compares results.
module bilinear_grid_checker import gbi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic                cmd,
  input  logic [ADDR_W-1:0]   load_index,
  input  logic signed [31:0]  load_value,
  input  logic signed [31:0]  coord_r,
  input  logic signed [31:0]  coord_z,
  input  logic                strobe,
  input  logic signed [31:0]  value,
  input  logic                status,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  mismatches,
  output int                  outstanding
);

  localparam logic STATUS_OK           = 1'b0;
  localparam logic STATUS_OUT_OF_RANGE = 1'b1;

  typedef struct packed {
    logic signed [31:0] coord_r;
    logic signed [31:0] coord_z;
    logic signed [31:0] value;
    logic               status;
  } interp_result_t;

  logic signed [31:0] grid_copy [TABLE_DEPTH];
  logic signed [31:0] r_lo, r_hi, z_lo, z_hi;
  logic [31:0]        r_inv, z_inv;
  logic [PTS_W-1:0]   pts_r, pts_z;
  interp_result_t     pending_interp [$];

  function automatic int clamp_points(logic [PTS_W-1:0] p, int maxp);
    if (p < 2) return 2;
    if (p > maxp) return maxp;
    return int'(p);
  endfunction

  // offset times reciprocal step is Q32.32: integer part picks the cell, top 16 of the rest is frac
  function automatic void locate_cell(input logic [31:0] off, input logic [31:0] inv,
                                      input int pts, output int idx_out, output longint frac);
    logic [63:0] prod;
    prod = {32'd0, off} * {32'd0, inv};
    if (prod[63:32] >= 32'(pts - 1)) begin
      idx_out = pts - 2;
      frac = 65536;
    end else begin
      idx_out = int'(prod[63:32]);
      frac = longint'(prod[31:16]);
    end
  endfunction

  // round half up, floor via arithmetic shift
  function automatic longint blend_q16(longint a, longint b, longint f);
    longint x;
    x = a * (65536 - f) + b * f + 32768;
    return x >>> 16;
  endfunction

  function automatic interp_result_t interpolate(logic signed [31:0] cr, logic signed [31:0] cz);
    interp_result_t res;
    int pr, pz, ir, iz, base;
    longint dr, dz, fr, fz, c0, c1, v;
    res.coord_r = cr;
    res.coord_z = cz;
    if (cr < r_lo || cr > r_hi || cz < z_lo || cz > z_hi) begin
      res.value = '0;
      res.status = STATUS_OUT_OF_RANGE;
      return res;
    end
    pr = clamp_points(pts_r, MAX_POINTS_R);
    pz = clamp_points(pts_z, MAX_POINTS_Z);
    dr = longint'(cr) - longint'(r_lo);
    dz = longint'(cz) - longint'(z_lo);
    locate_cell(dr[31:0], r_inv, pr, ir, fr);
    locate_cell(dz[31:0], z_inv, pz, iz, fz);
    base = iz * pr + ir;
    c0 = blend_q16(grid_copy[base], grid_copy[base + 1], fr);
    c1 = blend_q16(grid_copy[base + pr], grid_copy[base + pr + 1], fr);
    v = blend_q16(c0, c1, fz);
    res.value = v[31:0];
    res.status = STATUS_OK;
    return res;
  endfunction

  always @(posedge clk) begin
    interp_result_t want;
    if (rst) begin
      r_lo = '0;
      r_hi = '0;
      z_lo = '0;
      z_hi = '0;
      r_inv = 32'd65536;
      z_inv = 32'd65536;
      pts_r = PTS_W'(2);
      pts_z = PTS_W'(2);
      pending_interp.delete();
      mismatches <= 0;
      outstanding <= 0;
    end else begin
      if (strobe) begin
        if (pending_interp.size() == 0) begin
          if (mismatches < 10)
            $display("result word with no evaluate pending: value %h status %b", value, status);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_interp.pop_front();
          if (want.value !== value || want.status !== status) begin
            if (mismatches < 10)
              $display("mismatch at r=%h z=%h: expected value %h status %b, got value %h status %b",
                       want.coord_r, want.coord_z, want.value, want.status, value, status);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_R_LOWER:    r_lo = cfg_data;
          REG_R_UPPER:    r_hi = cfg_data;
          REG_Z_LOWER:    z_lo = cfg_data;
          REG_Z_UPPER:    z_hi = cfg_data;
          REG_R_STEP_INV: r_inv = cfg_data;
          REG_Z_STEP_INV: z_inv = cfg_data;
          REG_POINTS_R:   pts_r = cfg_data[PTS_W-1:0];
          REG_POINTS_Z:   pts_z = cfg_data[PTS_W-1:0];
          default: ;
        endcase
      end
      // loads land in the table in order with evaluate reads, so update right away
      if (start && !busy) begin
        if (cmd == CMD_LOAD) grid_copy[load_index] = load_value;
        else pending_interp.push_back(interpolate(coord_r, coord_z));
      end
      outstanding <= pending_interp.size();
    end
  end

endmodule

@@ verif/tb_bilinear_grid_interpolator.sv @@
// Testbench top for the bilinear grid interpolator: stimulus, configuration phases and verdict.
module tb_bilinear_grid_interpolator;
  import gbi_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RANDOM_PHASES   = 12;
  localparam int WORDS_PER_PHASE = 115;
  localparam int SETTLE_CYCLES   = PIPE_LATENCY + 4;

  localparam int AXIS_NATURAL     = 0;
  localparam int AXIS_FULL        = 1;
  localparam int AXIS_INVERTED    = 2;
  localparam int AXIS_EXTREME_INV = 3;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               cmd;
  logic [ADDR_W-1:0]  load_index;
  logic signed [31:0] load_value;
  logic signed [31:0] coord_r;
  logic signed [31:0] coord_z;
  logic               strobe;
  logic signed [31:0] value;
  logic               status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;
  int   burst_left;
  logic loaded [TABLE_DEPTH];

  bilinear_grid_interpolator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .load_index(load_index), .load_value(load_value), .coord_r(coord_r), .coord_z(coord_z),
    .strobe(strobe), .value(value), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bilinear_grid_checker interp_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .load_index(load_index), .load_value(load_value), .coord_r(coord_r), .coord_z(coord_z),
    .strobe(strobe), .value(value), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bilinear_grid_interpolator test failed");
      $finish;
    end
  end

  function automatic int eff_points(logic [PTS_W-1:0] p);
    return (p < 2) ? 2 : (p > MAX_POINTS_R) ? MAX_POINTS_R : int'(p);
  endfunction

  function automatic logic [31:0] sample_value();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [31:0] pick_coord(logic signed [31:0] lo, logic signed [31:0] hi);
    longint      l, h, pos;
    logic [63:0] r64, span;
    l = lo;
    h = hi;
    case ($urandom_range(0, 15))
      0: return lo;
      1: return hi;
      2: return (l > -64'sd2147483648) ? lo - 1 : $urandom();
      3: return (h < 64'sd2147483647) ? hi + 1 : $urandom();
      4, 5: return $urandom();
      default: begin
        if (l > h) return $urandom();
        span = h - l + 1;
        r64 = {$urandom(), $urandom()};
        pos = l + longint'(r64 % span);
        return pos[31:0];
      end
    endcase
  endfunction

  function automatic void random_axis(input int kind, output logic [31:0] lo, output logic [31:0] hi,
                                      output logic [31:0] inv, output logic [PTS_W-1:0] pts);
    int          n, step, base;
    logic [63:0] q;
    case (kind)
      AXIS_FULL: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
        inv = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 18);
        pts = PTS_W'($urandom_range(0, 8));
      end
      AXIS_INVERTED: begin
        base = $urandom_range(0, 1 << 24);
        lo = base;
        hi = base - int'($urandom_range(1, 1 << 16));
        inv = $urandom_range(1 << 12, 1 << 20);
        pts = $urandom_range(2, 8);
      end
      default: begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 16) : $urandom_range(2, 8);
        step = $urandom_range(1 << 10, 1 << 22);
        base = int'($urandom_range(0, 1 << 25)) - (1 << 24);
        lo = base;
        hi = base + (n - 1) * step;
        q = 64'h1_0000_0000 / 64'(step);
        inv = q[31:0];
        if (kind == AXIS_EXTREME_INV) inv = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        // point counts below 2 saturate up
        pts = ($urandom_range(0, 9) == 0) ? PTS_W'($urandom_range(0, 1)) : PTS_W'(n);
      end
    endcase
  endfunction

  function automatic grid_cfg_t random_grid(int phase);
    grid_cfg_t c;
    int kr, kz;
    kr = AXIS_NATURAL;
    kz = AXIS_NATURAL;
    case (phase % 6)
      3: begin
        kr = AXIS_FULL;
        kz = $urandom_range(0, 1) ? AXIS_FULL : AXIS_NATURAL;
      end
      4: if ($urandom_range(0, 1)) kr = AXIS_INVERTED; else kz = AXIS_INVERTED;
      5: begin
        kr = AXIS_EXTREME_INV;
        kz = AXIS_EXTREME_INV;
      end
      default: ;
    endcase
    random_axis(kr, c.r_lower, c.r_upper, c.r_step_inv, c.points_r);
    random_axis(kz, c.z_lower, c.z_upper, c.z_step_inv, c.points_z);
    return c;
  endfunction

  task automatic issue_word(cmd_t c, logic [ADDR_W-1:0] idx, logic [31:0] val,
                            logic [31:0] cr, logic [31:0] cz);
    @(negedge clk);
    start = 1'b1;
    cmd = c;
    load_index = idx;
    load_value = val;
    coord_r = cr;
    coord_z = cz;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // bursts of random length, random gaps between them
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      repeat ($urandom_range(1, 20)) begin
        @(negedge clk);
        start = 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 40);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // loads give no result word, so wait out the pipeline after the last one
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_entry(logic [ADDR_W-1:0] idx, logic [31:0] val);
    issue_word(CMD_LOAD, idx, val, $urandom(), $urandom());
    loaded[idx] = 1'b1;
    pace();
  endtask

  task automatic eval_point(logic [31:0] cr, logic [31:0] cz);
    issue_word(CMD_EVAL, ADDR_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom(), cr, cz);
    pace();
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_config(grid_cfg_t c);
    write_reg(REG_R_LOWER, c.r_lower);
    write_reg(REG_R_UPPER, c.r_upper);
    write_reg(REG_Z_LOWER, c.z_lower);
    write_reg(REG_Z_UPPER, c.z_upper);
    write_reg(REG_R_STEP_INV, c.r_step_inv);
    write_reg(REG_Z_STEP_INV, c.z_step_inv);
    write_reg(REG_POINTS_R, 32'(c.points_r));
    write_reg(REG_POINTS_Z, 32'(c.points_z));
  endtask

  // every entry an in-range evaluate can touch must be loaded first
  task automatic fill_grid(grid_cfg_t c);
    int n;
    n = eff_points(c.points_r) * eff_points(c.points_z);
    for (int i = 0; i < n; i++)
      if (!loaded[i]) load_entry(ADDR_W'(i), sample_value());
  endtask

  task automatic random_traffic(grid_cfg_t c, int n);
    int region;
    region = eff_points(c.points_r) * eff_points(c.points_z);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        load_entry($urandom_range(0, 1) ? ADDR_W'($urandom_range(0, region - 1))
                                        : ADDR_W'($urandom_range(0, TABLE_DEPTH - 1)),
                   sample_value());
      else
        eval_point(pick_coord(c.r_lower, c.r_upper), pick_coord(c.z_lower, c.z_upper));
      if ($urandom_range(0, 299) == 0) drain();
    end
  endtask

  initial begin
    grid_cfg_t grid;
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_LOAD;
    load_index = '0;
    load_value = '0;
    coord_r = '0;
    coord_z = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_R_LOWER;
    cfg_data = '0;
    burst_left = 0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // reset config: 2x2 grid whose bounds hold only the origin
    load_entry(0, 32'h7FFF_FFFF);
    load_entry(1, 32'h8000_0000);
    load_entry(2, 32'hFFFF_FFFF);
    load_entry(3, 32'h0000_0000);
    load_entry(ADDR_W'(TABLE_DEPTH - 1), 32'h5A5A_A5A5);
    eval_point(32'h0, 32'h0);
    eval_point(32'h1, 32'h0);
    eval_point(32'h0, 32'hFFFF_FFFF);
    eval_point(32'h8000_0000, 32'h7FFF_FFFF);

    // 4x4 unit grid: corners, upper edge clamp, half and near-one fractions, just outside
    settle();
    grid = '{r_lower: 32'h0, r_upper: 32'h0003_0000, z_lower: 32'h0, z_upper: 32'h0003_0000,
             r_step_inv: 32'h0001_0000, z_step_inv: 32'h0001_0000,
             points_r: PTS_W'(4), points_z: PTS_W'(4)};
    write_config(grid);
    fill_grid(grid);
    eval_point(32'h0, 32'h0);
    eval_point(32'h0003_0000, 32'h0003_0000);
    eval_point(32'h0001_8000, 32'h0000_8000);
    eval_point(32'h0000_FFFF, 32'h0001_FFFF);
    eval_point(32'h0003_0001, 32'h0);
    eval_point(32'hFFFF_FFFF, 32'h0);

    // point counts out of range saturate; extreme reciprocals
    settle();
    grid.points_r = PTS_W'(0);
    grid.points_z = PTS_W'(127);
    grid.r_step_inv = 32'hFFFF_FFFF;
    grid.z_step_inv = 32'h0;
    write_config(grid);
    fill_grid(grid);
    eval_point(32'h0, 32'h0);
    eval_point(32'h1, 32'h0003_0000);
    eval_point(32'h0003_0000, 32'h1);

    // lower above upper: nothing is in range
    settle();
    grid = '{r_lower: 32'h0001_0000, r_upper: 32'h0, z_lower: 32'h0, z_upper: 32'h0001_0000,
             r_step_inv: 32'h0001_0000, z_step_inv: 32'h0001_0000,
             points_r: PTS_W'(2), points_z: PTS_W'(2)};
    write_config(grid);
    fill_grid(grid);
    eval_point(32'h0, 32'h0);
    eval_point(32'h0001_0000, 32'h0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      grid = random_grid(ph);
      write_config(grid);
      fill_grid(grid);
      random_traffic(grid, WORDS_PER_PHASE);
    end

    settle();
    if (mismatches == 0) begin
      $display("bilinear_grid_interpolator test passed");
    end else begin
      $display("bilinear_grid_interpolator test failed");
    end
    $finish;
  end

endmodule
